// ===== design/huffman_utf8_stream_decoder_assert.svh =====
// Assertion macros for the Huffman stream decoder.
// Depends on clk and rst being visible where a macro is used.
`ifndef HUFFMAN_UTF8_STREAM_DECODER_ASSERT_SVH
`define HUFFMAN_UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HUD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hud assertion failed");

// Next-cycle implication, checked outside reset.
`define HUD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hud assertion failed");

`endif

// ===== design/hud_pkg.sv =====
// Shared types and constants for the Huffman stream decoder.
// No dependencies.
package hud_pkg;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_HDR  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // File parse phase
  typedef enum logic [6:0] {
    PH_WIDTH   = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_TABLE   = 7'b0000100,
    PH_TOTAL   = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_t;

  // Sequencer state
  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_PROC   = 14'b00000000000010,
    ST_ERR    = 14'b00000000000100,
    ST_FIN    = 14'b00000000001000,
    ST_B_LOOP = 14'b00000000010000,
    ST_B_RX   = 14'b00000000100000,
    ST_B_RY   = 14'b00000001000000,
    ST_B_GY   = 14'b00000010000000,
    ST_B_SRD  = 14'b00000100000000,
    ST_B_SCMP = 14'b00001000000000,
    ST_W_RD   = 14'b00010000000000,
    ST_W_USE  = 14'b00100000000000,
    ST_SYM_RD = 14'b01000000000000,
    ST_SYM_EM = 14'b10000000000000
  } state_t;

  // Byte count of a UTF-8 symbol from its lead byte, 0 if not a lead byte
  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    if (b[7] == 1'b0)              r = 3'd1;
    else if (b[7:5] == 3'b110)     r = 3'd2;
    else if (b[7:4] == 4'b1110)    r = 3'd3;
    else if (b[7:3] == 5'b11110)   r = 3'd4;
    return r;
  endfunction

endpackage

// ===== design/hud_in_if.sv =====
// Input channel of the Huffman stream decoder: one file byte per transaction.
// No dependencies.
interface hud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== design/hud_out_if.sv =====
// Output channel of the Huffman stream decoder: one decoded byte per transaction.
// No dependencies.
interface hud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

// ===== design/huffman_utf8_stream_decoder.sv =====
// Huffman stream decoder top level: header parser, tree builder and tree walker.
// Depends on hud_pkg, hud_in_if, hud_out_if and the assertion macro header.
//
// Usage:
//   in_ch takes the compressed file one byte per transaction; in_last marks
//   the final byte of a file, after which all parse state returns to reset.
//   out_ch gives decoded UTF-8 bytes; out_last marks the final byte caused by
//   one input byte, status flags a malformed header or a full symbol table
//   (one result with out_byte 0, then the rest of the file is swallowed).
//   A payload byte is walked bit by bit, and each decoded symbol sends its
//   bytes out one by one; with a single symbol each bit decodes to that
//   symbol without a walk. The walk is set by one node-memory read per
//   bit. After the last header byte the tree build merges the two list
//   heads and inserts their sum by scanning later entries with the shared compare.
//   in_ch is not ready while one byte is in work. A stalled receiver holds
//   the output register and the pending result and halts the output states.
//   Reset (rst, synchronous) clears the parser; symbol, tree and list
//   memories are not cleared and are read only where written.
`include "huffman_utf8_stream_decoder_assert.svh"

module huffman_utf8_stream_decoder
  import hud_pkg::*;
#(
  parameter int MAX_SYMBOLS      = 256,
  parameter int CNT_WIDTH        = 40,
  parameter int MAX_SYMBOL_BYTES = 4
) (
  input  logic      clk,
  input  logic      rst,
  hud_in_if.sink    in_ch,
  hud_out_if.source out_ch
);

  localparam int IW     = $clog2(MAX_SYMBOLS);
  localparam int CW     = $clog2(MAX_SYMBOLS + 1);
  localparam int NSLOTS = 2 * MAX_SYMBOLS - 1;
  localparam int NW     = $clog2(NSLOTS);
  localparam int SBW    = 8 * MAX_SYMBOL_BYTES;
  localparam int MLW    = CNT_WIDTH + NW;
  localparam int SMW    = SBW + 3;
  localparam logic [63:0] CMAX64 = (64'd1 << CNT_WIDTH) - 64'd1;

  // Memories
  logic [SMW-1:0]  sym_mem  [MAX_SYMBOLS];
  logic [MLW-1:0]  ml_mem   [MAX_SYMBOLS];
  logic [2*NW-1:0] node_mem [NSLOTS];

  // Control and parse registers
  state_t          state;
  phase_t          phase;
  logic [2:0]      count_width;
  logic [31:0]     tbl_left;
  logic [63:0]     acc;
  logic [3:0]      fbi;
  logic [2:0]      cur_len;
  logic [SBW-1:0]  cur_sym;
  logic [CW-1:0]   sym_total;
  logic [63:0]     bits_rem;
  logic [NW-1:0]   walk_node;
  logic [7:0]      byte_r;
  logic            last_r;
  logic [3:0]      bit_j;
  logic [2:0]      k;
  logic            pend_valid;
  logic [7:0]      pend_byte;
  logic [1:0]      err_code;
  logic            out_valid;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic [1:0]      status_r;

  // Tree build registers
  logic [CW-1:0]        head;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        scan_i;
  logic [NW-1:0]        next_node;
  logic [NW-1:0]        z_node;
  logic [CNT_WIDTH-1:0] x_cnt;
  logic [NW-1:0]        x_node;
  logic [CNT_WIDTH-1:0] z_cnt;
  logic [IW-1:0]        ml_ra;
  logic [IW-1:0]        sym_ra;
  logic [MLW-1:0]       ml_q;
  logic [SMW-1:0]       sym_q;
  logic [2*NW-1:0]      node_q;

  // Header byte decode results
  phase_t               p_phase;
  logic [1:0]           p_err;
  logic [63:0]          p_acc;
  logic [63:0]          p_bits;
  logic [3:0]           p_fbi;
  logic [31:0]          p_tbl;
  logic [SBW-1:0]       p_sym;
  logic [2:0]           p_len;
  logic [2:0]           p_cw;
  logic                 p_commit;
  logic                 p_total_done;
  logic [CNT_WIDTH-1:0] p_cnt;
  logic [2:0]           slen;
  logic [3:0]           cbyte_idx;
  logic [3:0]           entry_end;
  logic [63:0]          c64;

  // Shared arithmetic and misc
  logic                 out_free;
  logic                 out_load;
  logic [CNT_WIDTH:0]   zsum;
  logic [CNT_WIDTH-1:0] zsat;
  logic [CW:0]          twice_n;
  logic [NW-1:0]        root;
  logic                 cur_bit;
  logic [NW-1:0]        nx;
  logic                 nx_leaf;
  logic [7:0]           sym_byte;
  logic [CW-1:0]        list_end;
  logic                 ml_we;
  logic [IW-1:0]        ml_wa;
  logic [MLW-1:0]       ml_wd;

  assign out_free = !out_valid || out_ch.ready;
  // Output register takes a new transaction this cycle
  assign out_load = out_free && ((state == ST_ERR) ||
                                 (pend_valid && (state == ST_FIN || state == ST_SYM_EM)));
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;
  assign out_ch.status   = status_r;

  assign zsum    = {1'b0, x_cnt} + {1'b0, ml_q[MLW-1:NW]};
  assign zsat    = zsum[CNT_WIDTH] ? {CNT_WIDTH{1'b1}} : zsum[CNT_WIDTH-1:0];
  assign twice_n = {sym_total, 1'b0};
  assign root    = NW'(twice_n - (CW+1)'(2));
  assign cur_bit = byte_r[3'd7 - bit_j[2:0]];
  assign nx      = cur_bit ? node_q[2*NW-1:NW] : node_q[NW-1:0];
  assign nx_leaf = (NW+1)'(nx) < (NW+1)'(sym_total);
  assign list_end = head + cnt;

  // Byte k of the symbol just read
  always_comb begin
    sym_byte = 8'd0;
    for (int i = 0; i < MAX_SYMBOL_BYTES; i++) begin
      if (k == 3'(i)) sym_byte = sym_q[8*i +: 8];
    end
  end

  // Header parse of the latched byte
  always_comb begin
    p_phase = phase;
    p_err = STAT_OK;
    p_acc = acc;
    p_bits = 64'd0;
    p_fbi = fbi;
    p_tbl = tbl_left;
    p_sym = cur_sym;
    p_len = cur_len;
    p_cw = count_width;
    p_commit = 1'b0;
    p_total_done = 1'b0;
    slen = (fbi == 4'd0) ? utf8_len(byte_r) : cur_len;
    cbyte_idx = fbi - {1'b0, slen};
    entry_end = {1'b0, slen} + {1'b0, count_width};
    c64 = 64'd0;
    unique case (phase)
      PH_WIDTH: begin
        if (byte_r >= 8'd1 && byte_r <= 8'd4) begin
          p_cw = byte_r[2:0];
          p_acc = 64'd0;
          p_fbi = 4'd0;
          p_phase = PH_LEN;
        end else begin
          p_err = STAT_BAD_HDR;
        end
      end
      PH_LEN: begin
        p_acc[{fbi[1:0], 3'b000} +: 8] = byte_r;
        p_fbi = fbi + 4'd1;
        if (fbi == 4'd3) begin
          p_tbl = p_acc[31:0];
          p_acc = 64'd0;
          p_fbi = 4'd0;
          if (p_tbl == 32'd0) p_err = STAT_BAD_HDR;
          else p_phase = PH_TABLE;
        end
      end
      PH_TABLE: begin
        if (fbi == 4'd0) begin
          if (slen == 3'd0 || slen > 3'(MAX_SYMBOL_BYTES)) begin
            p_err = STAT_BAD_HDR;
          end else if (sym_total >= CW'(MAX_SYMBOLS)) begin
            p_err = STAT_OVERFLOW;
          end else begin
            p_len = slen;
            p_sym = SBW'(byte_r);
            p_acc = 64'd0;
          end
        end else if (fbi < {1'b0, cur_len}) begin
          for (int i = 1; i < MAX_SYMBOL_BYTES; i++) begin
            if (fbi == 4'(i)) p_sym[8*i +: 8] = byte_r;
          end
        end else begin
          p_acc[{cbyte_idx[1:0], 3'b000} +: 8] = byte_r;
        end
        if (p_err == STAT_OK) begin
          p_fbi = fbi + 4'd1;
          if (tbl_left != 32'd0) p_tbl = tbl_left - 32'd1;
          if (p_fbi >= entry_end) begin
            p_commit = 1'b1;
            c64 = {32'd0, p_acc[31:0]};
            p_fbi = 4'd0;
            p_acc = 64'd0;
            if (p_tbl == 32'd0) p_phase = PH_TOTAL;
          end
        end
      end
      PH_TOTAL: begin
        p_acc[{fbi[2:0], 3'b000} +: 8] = byte_r;
        p_fbi = fbi + 4'd1;
        if (fbi == 4'd7) begin
          p_bits = p_acc;
          p_acc = 64'd0;
          p_fbi = 4'd0;
          p_total_done = 1'b1;
          p_phase = (p_bits == 64'd0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      default: begin
      end
    endcase
    p_cnt = (c64 > CMAX64) ? CMAX64[CNT_WIDTH-1:0] : c64[CNT_WIDTH-1:0];
    if (p_err == STAT_OK && last_r &&
        (p_phase == PH_LEN || p_phase == PH_TABLE || p_phase == PH_TOTAL))
      p_err = STAT_BAD_HDR;
  end

  // Merge list write port
  always_comb begin
    ml_we = 1'b0;
    ml_wa = sym_total[IW-1:0];
    ml_wd = {p_cnt, NW'(sym_total)};
    priority if (state == ST_PROC) begin
      ml_we = p_commit && (p_err == STAT_OK);
    end else if (state == ST_B_SRD) begin
      ml_we = (scan_i == list_end);
      ml_wa = IW'(scan_i - CW'(1));
      ml_wd = {z_cnt, z_node};
    end else if (state == ST_B_SCMP) begin
      ml_we = 1'b1;
      ml_wa = IW'(scan_i - CW'(1));
      ml_wd = (ml_q[MLW-1:NW] >= z_cnt) ? {z_cnt, z_node} : ml_q;
    end else begin
      ml_we = 1'b0;
    end
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (state == ST_PROC && p_commit && p_err == STAT_OK)
      sym_mem[sym_total[IW-1:0]] <= {p_len, p_sym};
    if (ml_we) ml_mem[ml_wa] <= ml_wd;
    if (state == ST_B_GY) node_mem[next_node] <= {x_node, ml_q[NW-1:0]};
    sym_q  <= sym_mem[sym_ra];
    ml_q   <= ml_mem[ml_ra];
    node_q <= node_mem[walk_node];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_WIDTH;
      count_width <= 3'd0;
      tbl_left <= 32'd0;
      acc <= 64'd0;
      fbi <= 4'd0;
      sym_total <= '0;
      bits_rem <= 64'd0;
      walk_node <= '0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            byte_r <= in_ch.in_byte;
            last_r <= in_ch.in_last;
            state <= ST_PROC;
          end
        end
        ST_PROC: begin
          phase <= (p_err != STAT_OK) ? PH_ERROR : p_phase;
          acc <= p_acc;
          fbi <= p_fbi;
          tbl_left <= p_tbl;
          cur_sym <= p_sym;
          cur_len <= p_len;
          count_width <= p_cw;
          if (p_commit && p_err == STAT_OK) sym_total <= sym_total + CW'(1);
          if (p_total_done) bits_rem <= p_bits;
          if (p_err != STAT_OK) begin
            err_code <= p_err;
            state <= ST_ERR;
          end else if (p_total_done && !last_r && p_bits != 64'd0) begin
            head <= '0;
            cnt <= sym_total;
            next_node <= NW'(sym_total);
            state <= ST_B_LOOP;
          end else if (phase == PH_PAYLOAD) begin
            bit_j <= 4'd0;
            state <= ST_W_RD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte_r <= 8'd0;
            out_last_r <= 1'b1;
            status_r <= err_code;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (pend_valid) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_byte_r <= pend_byte;
              out_last_r <= 1'b1;
              status_r <= STAT_OK;
              pend_valid <= 1'b0;
            end
          end else begin
            if (last_r) begin
              phase <= PH_WIDTH;
              count_width <= 3'd0;
              tbl_left <= 32'd0;
              acc <= 64'd0;
              fbi <= 4'd0;
              sym_total <= '0;
              bits_rem <= 64'd0;
              walk_node <= '0;
            end
            state <= ST_IDLE;
          end
        end
        ST_B_LOOP: begin
          if (cnt <= CW'(1)) begin
            walk_node <= root;
            state <= ST_FIN;
          end else begin
            ml_ra <= head[IW-1:0];
            state <= ST_B_RX;
          end
        end
        ST_B_RX: begin
          ml_ra <= IW'(head + CW'(1));
          state <= ST_B_RY;
        end
        ST_B_RY: begin
          x_cnt <= ml_q[MLW-1:NW];
          x_node <= ml_q[NW-1:0];
          state <= ST_B_GY;
        end
        ST_B_GY: begin
          z_cnt <= zsat;
          z_node <= next_node;
          next_node <= next_node + NW'(1);
          head <= head + CW'(2);
          cnt <= cnt - CW'(2);
          scan_i <= head + CW'(2);
          ml_ra <= IW'(head + CW'(2));
          state <= ST_B_SRD;
        end
        ST_B_SRD: begin
          if (scan_i == list_end) begin
            head <= head - CW'(1);
            cnt <= cnt + CW'(1);
            state <= ST_B_LOOP;
          end else begin
            state <= ST_B_SCMP;
          end
        end
        ST_B_SCMP: begin
          if (ml_q[MLW-1:NW] >= z_cnt) begin
            head <= head - CW'(1);
            cnt <= cnt + CW'(1);
            state <= ST_B_LOOP;
          end else begin
            scan_i <= scan_i + CW'(1);
            ml_ra <= IW'(scan_i + CW'(1));
            state <= ST_B_SRD;
          end
        end
        ST_W_RD: begin
          if (bits_rem == 64'd0 || bit_j == 4'd8) begin
            if (bits_rem == 64'd0) phase <= PH_DONE;
            state <= ST_FIN;
          end else if (sym_total <= CW'(1)) begin
            sym_ra <= '0;
            bits_rem <= bits_rem - 64'd1;
            bit_j <= bit_j + 4'd1;
            state <= ST_SYM_RD;
          end else begin
            state <= ST_W_USE;
          end
        end
        ST_W_USE: begin
          bits_rem <= bits_rem - 64'd1;
          bit_j <= bit_j + 4'd1;
          if (nx_leaf) begin
            sym_ra <= IW'(nx);
            walk_node <= root;
            state <= ST_SYM_RD;
          end else begin
            walk_node <= nx;
            state <= ST_W_RD;
          end
        end
        ST_SYM_RD: begin
          k <= 3'd0;
          state <= ST_SYM_EM;
        end
        ST_SYM_EM: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid <= 1'b1;
              out_byte_r <= pend_byte;
              out_last_r <= 1'b0;
              status_r <= STAT_OK;
            end
            pend_valid <= 1'b1;
            pend_byte <= sym_byte;
            k <= k + 3'd1;
            if (k + 3'd1 >= sym_q[SMW-1:SBW]) state <= ST_W_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `HUD_ASSERT_IMPL(a_err_shape, out_valid && status_r != STAT_OK, out_last_r && out_byte_r == 8'd0)
  `HUD_ASSERT_IMPL(a_idle_no_pend, state == ST_IDLE, !pend_valid)
  `HUD_ASSERT_IMPL(a_walk_internal, state == ST_W_USE, (NW+1)'(walk_node) >= (NW+1)'(sym_total))
  `HUD_ASSERT_NEXT(a_accept_proc, in_ch.valid && in_ch.ready, state == ST_PROC)

endmodule
